@@ rtl/bra_pkg.sv @@
// Shared types and constants for the resource admission unit.
`default_nettype none
package bra_pkg;

  localparam int unsigned CustomersDef  = 5;
  localparam int unsigned ResourcesDef  = 4;
  localparam int unsigned CountWidthDef = 8;
  localparam int unsigned NumAmounts    = 4;
  localparam int unsigned AmountWidth   = 8;
  localparam int unsigned CustWidth     = 3;

  typedef enum logic [1:0] {
    CMD_LOAD_MAX  = 2'd0,
    CMD_LOAD_FREE = 2'd1,
    CMD_REQUEST   = 2'd2,
    CMD_RELEASE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_CLAIM    = 3'd1,
    ST_FREE     = 3'd2,
    ST_UNSAFE   = 3'd3,
    ST_DONE     = 3'd4,
    ST_BADCUST  = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]             command;
    logic [CustWidth-1:0]   customer;
    logic [AmountWidth-1:0] amount_0;
    logic [AmountWidth-1:0] amount_1;
    logic [AmountWidth-1:0] amount_2;
    logic [AmountWidth-1:0] amount_3;
  } req_t;

  typedef struct packed {
    logic [2:0]             status;
    logic [AmountWidth-1:0] free_0;
    logic [AmountWidth-1:0] free_1;
    logic [AmountWidth-1:0] free_2;
    logic [AmountWidth-1:0] free_3;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_APPLY,
    S_SCAN_RD,
    S_SCAN,
    S_PASS_END,
    S_ROLLBACK,
    S_OUT
  } state_e;

endpackage
`default_nettype wire

@@ rtl/bankers_resource_admission_unit.sv @@
// Banker's algorithm admission unit: command sequencer around the row memory.
//
// One command item in on req_valid_i/req_ready_o, one response item out on
// rsp_valid_o/rsp_ready_i. Each item carries a command (load claim row, load
// free vector, request, release), a customer and four amounts; each response
// carries a status and the free vector after the command.
// Claim and held rows live in one synchronous memory. A request that reaches
// the safety check runs passes over all rows, each row read in S_SCAN_RD and
// checked in S_SCAN and each pass ended in S_PASS_END, until all customers
// finish or a pass finishes no new one: up to CUSTOMERS passes.
// One item is in work at a time.
// Reset clears the free vector and the memory through a sweep over all rows,
// during which no item is taken. The response waits in its register
// while the receiver stalls; the next item is taken once it has left.
`default_nettype none
module bankers_resource_admission_unit #(
  parameter int unsigned Customers  = bra_pkg::CustomersDef,
  parameter int unsigned Resources  = bra_pkg::ResourcesDef,
  parameter int unsigned CountWidth = bra_pkg::CountWidthDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         req_valid_i,
  output logic              req_ready_o,
  input  wire bra_pkg::req_t req_i,
  output logic              rsp_valid_o,
  input  wire logic         rsp_ready_i,
  output bra_pkg::rsp_t     rsp_o
);

  localparam int unsigned Aw  = (Customers > 1) ? $clog2(Customers) : 1;
  localparam int unsigned Kw  = bra_pkg::CustWidth;
  localparam int unsigned Cw  = CountWidth;
  localparam int unsigned Ww  = Cw + $clog2(Customers + 1);
  localparam int unsigned Rw  = 2 * Resources * Cw;
  localparam int unsigned Aa  = bra_pkg::AmountWidth;
  localparam int unsigned Pw  = $clog2(Customers + 2);
  localparam logic [Cw-1:0] CountMax = {Cw{1'b1}};

  bra_pkg::state_e state_q, state_d;
  logic            clearing_q;
  logic [Aw-1:0]   clr_q;
  logic [Cw-1:0]   free_q [Resources];
  logic [Cw-1:0]   free_d [Resources];
  logic [Ww-1:0]   work_q [Resources];
  logic [Ww-1:0]   work_d [Resources];
  logic [Cw-1:0]   amt_q [Resources];
  logic [1:0]      cmd_q;
  logic [Kw-1:0]   cust_q;
  logic [Customers-1:0] done_q, done_d;
  logic            prog_q, prog_d;
  logic [Aw-1:0]   idx_q, idx_d;
  logic [Pw-1:0]   pass_q, pass_d;
  logic [2:0]      status_q, status_d;
  logic            rsp_valid_q;

  logic            we;
  logic [Aw-1:0]   waddr, raddr;
  logic [Rw-1:0]   wdata, rdata;
  logic [Cw-1:0]   claim_r [Resources];
  logic [Cw-1:0]   held_r [Resources];
  logic [Aa-1:0]   amt_in [bra_pkg::NumAmounts];
  logic            cust_ok;

  bra_table #(.Customers(Customers), .RowWidth(Rw)) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign amt_in[0] = req_i.amount_0;
  assign amt_in[1] = req_i.amount_1;
  assign amt_in[2] = req_i.amount_2;
  assign amt_in[3] = req_i.amount_3;

  always_comb begin
    for (int r = 0; r < Resources; r++) begin
      claim_r[r] = rdata[(2*r+1)*Cw +: Cw];
      held_r[r]  = rdata[(2*r)*Cw +: Cw];
    end
  end

  assign cust_ok     = ({1'b0, cust_q} < (Kw+1)'(Customers));
  assign req_ready_o = (state_q == bra_pkg::S_IDLE) && !clearing_q && !rsp_valid_q;
  assign rsp_valid_o = rsp_valid_q;

  always_comb begin
    logic [Cw:0]   need;
    logic          fits;
    logic          claim_bad, free_bad;
    logic [Cw:0]   sum;
    logic [Cw-1:0] give;
    state_d  = state_q;
    done_d   = done_q;
    prog_d   = prog_q;
    idx_d    = idx_q;
    pass_d   = pass_q;
    status_d = status_q;
    we       = 1'b0;
    waddr    = cust_q[Aw-1:0];
    wdata    = '0;
    raddr    = cust_q[Aw-1:0];
    need      = '0;
    fits      = 1'b1;
    claim_bad = 1'b0;
    free_bad  = 1'b0;
    sum       = '0;
    give      = '0;
    for (int r = 0; r < Resources; r++) begin
      free_d[r] = free_q[r];
      work_d[r] = work_q[r];
    end
    if (clearing_q) begin
      we    = 1'b1;
      waddr = clr_q;
    end
    case (state_q)
      bra_pkg::S_IDLE: begin
        if (req_valid_i && req_ready_o) begin
          if (req_i.command == bra_pkg::CMD_LOAD_FREE) begin
            for (int r = 0; r < Resources; r++) begin
              free_d[r] = (Aa > Cw && amt_in[r] > Aa'(CountMax)) ? CountMax : Cw'(amt_in[r]);
            end
            status_d = bra_pkg::ST_DONE;
            state_d  = bra_pkg::S_OUT;
          end else begin
            state_d = bra_pkg::S_RD;
          end
        end
      end
      bra_pkg::S_RD: begin
        if (!cust_ok) begin
          status_d = bra_pkg::ST_BADCUST;
          state_d  = bra_pkg::S_OUT;
        end else begin
          state_d = bra_pkg::S_CHK;
        end
      end
      bra_pkg::S_CHK: begin
        status_d = bra_pkg::ST_DONE;
        state_d  = bra_pkg::S_OUT;
        if (cmd_q == bra_pkg::CMD_LOAD_MAX) begin
          we = 1'b1;
          for (int r = 0; r < Resources; r++) begin
            wdata[(2*r+1)*Cw +: Cw] = amt_q[r];
            wdata[(2*r)*Cw +: Cw]   = held_r[r];
          end
        end else if (cmd_q == bra_pkg::CMD_RELEASE) begin
          we = 1'b1;
          for (int r = 0; r < Resources; r++) begin
            give = (amt_q[r] > held_r[r]) ? held_r[r] : amt_q[r];
            wdata[(2*r+1)*Cw +: Cw] = claim_r[r];
            wdata[(2*r)*Cw +: Cw]   = held_r[r] - give;
            sum = {1'b0, free_q[r]} + {1'b0, give};
            free_d[r] = sum[Cw] ? CountMax : sum[Cw-1:0];
          end
        end else begin
          for (int r = 0; r < Resources; r++) begin
            need = (claim_r[r] > held_r[r]) ? {1'b0, claim_r[r] - held_r[r]} : '0;
            if ({1'b0, amt_q[r]} > need) claim_bad = 1'b1;
            if (amt_q[r] > free_q[r]) free_bad = 1'b1;
          end
          if (claim_bad) begin
            status_d = bra_pkg::ST_CLAIM;
          end else if (free_bad) begin
            status_d = bra_pkg::ST_FREE;
          end else begin
            // apply tentatively, then start the safety scan
            we = 1'b1;
            for (int r = 0; r < Resources; r++) begin
              wdata[(2*r+1)*Cw +: Cw] = claim_r[r];
              wdata[(2*r)*Cw +: Cw]   = held_r[r] + amt_q[r];
              free_d[r] = free_q[r] - amt_q[r];
              work_d[r] = Ww'(free_q[r] - amt_q[r]);
            end
            done_d  = '0;
            prog_d  = 1'b0;
            idx_d   = '0;
            pass_d  = '0;
            state_d = bra_pkg::S_SCAN_RD;
          end
        end
      end
      bra_pkg::S_SCAN_RD: begin
        raddr   = idx_q;
        state_d = bra_pkg::S_SCAN;
      end
      bra_pkg::S_SCAN: begin
        if (!done_q[idx_q]) begin
          for (int r = 0; r < Resources; r++) begin
            need = (claim_r[r] > held_r[r]) ? {1'b0, claim_r[r] - held_r[r]} : '0;
            if (Ww'(need) > work_q[r]) fits = 1'b0;
          end
          if (fits) begin
            done_d[idx_q] = 1'b1;
            prog_d        = 1'b1;
            for (int r = 0; r < Resources; r++) begin
              work_d[r] = work_q[r] + Ww'(held_r[r]);
            end
          end
        end
        if ({1'b0, idx_q} == (Aw+1)'(Customers - 1)) begin
          state_d = bra_pkg::S_PASS_END;
        end else begin
          idx_d   = idx_q + Aw'(1);
          state_d = bra_pkg::S_SCAN_RD;
        end
      end
      bra_pkg::S_PASS_END: begin
        if (&done_q) begin
          status_d = bra_pkg::ST_GRANTED;
          state_d  = bra_pkg::S_OUT;
        end else if (!prog_q) begin
          raddr   = cust_q[Aw-1:0];
          state_d = bra_pkg::S_ROLLBACK;
        end else begin
          prog_d  = 1'b0;
          idx_d   = '0;
          pass_d  = pass_q + Pw'(1);
          state_d = bra_pkg::S_SCAN_RD;
        end
      end
      bra_pkg::S_ROLLBACK: begin
        we = 1'b1;
        for (int r = 0; r < Resources; r++) begin
          wdata[(2*r+1)*Cw +: Cw] = claim_r[r];
          wdata[(2*r)*Cw +: Cw]   = held_r[r] - amt_q[r];
          free_d[r] = free_q[r] + amt_q[r];
        end
        status_d = bra_pkg::ST_UNSAFE;
        state_d  = bra_pkg::S_OUT;
      end
      bra_pkg::S_OUT: begin
        state_d = bra_pkg::S_IDLE;
      end
      default: begin
        state_d = bra_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bra_pkg::S_IDLE;
      clearing_q  <= 1'b1;
      clr_q       <= '0;
      rsp_valid_q <= 1'b0;
      done_q      <= '0;
      prog_q      <= 1'b0;
      idx_q       <= '0;
      pass_q      <= '0;
      status_q    <= bra_pkg::ST_DONE;
      for (int r = 0; r < Resources; r++) begin
        free_q[r] <= '0;
      end
    end else begin
      state_q  <= state_d;
      done_q   <= done_d;
      prog_q   <= prog_d;
      idx_q    <= idx_d;
      pass_q   <= pass_d;
      status_q <= status_d;
      for (int r = 0; r < Resources; r++) begin
        free_q[r] <= free_d[r];
      end
      if (clearing_q) begin
        if ({1'b0, clr_q} == (Aw+1)'(Customers - 1)) begin
          clearing_q <= 1'b0;
        end else begin
          clr_q <= clr_q + Aw'(1);
        end
      end
      if (state_q == bra_pkg::S_OUT) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // item payload and scratch registers
  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      cmd_q  <= req_i.command;
      cust_q <= req_i.customer;
      for (int r = 0; r < Resources; r++) begin
        amt_q[r] <= (Aa > Cw && amt_in[r] > Aa'(CountMax)) ? CountMax : Cw'(amt_in[r]);
      end
    end
    for (int r = 0; r < Resources; r++) begin
      work_q[r] <= work_d[r];
    end
  end

  always_comb begin
    logic [Aa-1:0] f [bra_pkg::NumAmounts];
    for (int j = 0; j < bra_pkg::NumAmounts; j++) begin
      f[j] = '0;
    end
    for (int r = 0; r < Resources; r++) begin
      f[r] = Aa'(free_q[r]);
    end
    rsp_o.status = status_q;
    rsp_o.free_0 = f[0];
    rsp_o.free_1 = f[1];
    rsp_o.free_2 = f[2];
    rsp_o.free_3 = f[3];
  end

  a_no_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != bra_pkg::S_IDLE) |-> !req_ready_o)
    else $error("item taken while busy");
  a_pass_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, pass_q} <= (Pw+1)'(Customers)))
    else $error("safety scan ran too many passes");
  a_rsp_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_ready_i) |=> (rsp_valid_o && $stable(rsp_o)))
    else $error("response changed while stalled");
  a_no_rsp_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> (state_q == bra_pkg::S_IDLE))
    else $error("work during clearing sweep");

endmodule
`default_nettype wire

@@ rtl/bra_table.sv @@
// Customer row memory: claim and held rows, one synchronous read and one write port.
`default_nettype none
module bra_table #(
  parameter int unsigned Customers  = bra_pkg::CustomersDef,
  parameter int unsigned RowWidth   = 32,
  localparam int unsigned AddrWidth = (Customers > 1) ? $clog2(Customers) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AddrWidth-1:0] waddr_i,
  input  wire logic [RowWidth-1:0]  wdata_i,
  input  wire logic [AddrWidth-1:0] raddr_i,
  output logic      [RowWidth-1:0]  rdata_o
);

  logic [RowWidth-1:0] mem_q [Customers];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking testbench for the banker's algorithm admission unit.
`default_nettype none
module tb_top;

  localparam int unsigned NCust = bra_pkg::CustomersDef;
  localparam int unsigned NRes  = bra_pkg::ResourcesDef;
  localparam int unsigned CMax  = (1 << bra_pkg::CountWidthDef) - 1;
  localparam int unsigned NRand = 1150;
  localparam int unsigned NDir  = 20;
  localparam logic [3:0]  STX   = 4'hF;  // no typed-in status

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic req_valid = 1'b0;
  logic req_ready;
  bra_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  bra_pkg::rsp_t rsp;

  always #5 clk = ~clk;

  bankers_resource_admission_unit dut (
    .clk_i(clk), .rst_ni(rst_n),
    .req_valid_i(req_valid), .req_ready_o(req_ready), .req_i(req),
    .rsp_valid_o(rsp_valid), .rsp_ready_i(rsp_ready), .rsp_o(rsp)
  );

  int unsigned free_v [NRes];
  int unsigned claim_t [NCust][NRes];
  int unsigned held_t [NCust][NRes];
  bra_pkg::rsp_t rsp_q [$];
  logic [3:0]  typed_q [$];
  int          errors = 0;
  int          hold_off = 0;
  bit          stim_done = 1'b0;

  function automatic int unsigned sat(int unsigned v);
    return v > CMax ? CMax : v;
  endfunction

  function automatic int unsigned need(int c, int r);
    return claim_t[c][r] > held_t[c][r] ? claim_t[c][r] - held_t[c][r] : 0;
  endfunction

  function automatic bit is_safe();
    int unsigned work [NRes];
    bit fin [NCust];
    int cnt;
    bit prog;
    bit fits;
    cnt = 0;
    prog = 1'b1;
    for (int r = 0; r < NRes; r++) work[r] = free_v[r];
    for (int c = 0; c < NCust; c++) fin[c] = 1'b0;
    while (prog) begin
      prog = 1'b0;
      for (int c = 0; c < NCust; c++) begin
        if (!fin[c]) begin
          fits = 1'b1;
          for (int r = 0; r < NRes; r++) if (need(c, r) > work[r]) fits = 1'b0;
          if (fits) begin
            fin[c] = 1'b1;
            cnt++;
            prog = 1'b1;
            for (int r = 0; r < NRes; r++) work[r] += held_t[c][r];
          end
        end
      end
    end
    return cnt == NCust;
  endfunction

  // Advance the admission state by one command and return the response.
  function automatic bra_pkg::rsp_t admit(bra_pkg::req_t q);
    int unsigned amt [NRes];
    bra_pkg::status_e st;
    bra_pkg::rsp_t o;
    int c;
    int unsigned g;
    logic [7:0] a [4];
    a = '{q.amount_0, q.amount_1, q.amount_2, q.amount_3};
    for (int r = 0; r < NRes; r++) amt[r] = a[r];
    c = q.customer;
    st = bra_pkg::ST_DONE;
    if (bra_pkg::cmd_e'(q.command) == bra_pkg::CMD_LOAD_FREE) begin
      for (int r = 0; r < NRes; r++) free_v[r] = sat(amt[r]);
    end else if (c >= NCust) begin
      st = bra_pkg::ST_BADCUST;
    end else if (bra_pkg::cmd_e'(q.command) == bra_pkg::CMD_LOAD_MAX) begin
      for (int r = 0; r < NRes; r++) claim_t[c][r] = sat(amt[r]);
    end else if (bra_pkg::cmd_e'(q.command) == bra_pkg::CMD_REQUEST) begin
      st = bra_pkg::ST_GRANTED;
      for (int r = 0; r < NRes; r++) if (amt[r] > need(c, r)) st = bra_pkg::ST_CLAIM;
      if (st == bra_pkg::ST_GRANTED)
        for (int r = 0; r < NRes; r++) if (amt[r] > free_v[r]) st = bra_pkg::ST_FREE;
      if (st == bra_pkg::ST_GRANTED) begin
        for (int r = 0; r < NRes; r++) begin
          held_t[c][r] += amt[r];
          free_v[r] -= amt[r];
        end
        if (!is_safe()) begin
          st = bra_pkg::ST_UNSAFE;
          for (int r = 0; r < NRes; r++) begin
            held_t[c][r] -= amt[r];
            free_v[r] += amt[r];
          end
        end
      end
    end else begin
      for (int r = 0; r < NRes; r++) begin
        g = amt[r] > held_t[c][r] ? held_t[c][r] : amt[r];
        held_t[c][r] -= g;
        free_v[r] = sat(free_v[r] + g);
      end
    end
    o.status = st;
    o.free_0 = NRes > 0 ? free_v[0][7:0] : 8'd0;
    o.free_1 = NRes > 1 ? free_v[1][7:0] : 8'd0;
    o.free_2 = NRes > 2 ? free_v[2][7:0] : 8'd0;
    o.free_3 = NRes > 3 ? free_v[3][7:0] : 8'd0;
    return o;
  endfunction

  function automatic bra_pkg::req_t mk(bra_pkg::cmd_e cmd, int c,
                                       int a0, int a1, int a2, int a3);
    bra_pkg::req_t q;
    q.command = cmd;
    q.customer = c[2:0];
    q.amount_0 = a0[7:0];
    q.amount_1 = a1[7:0];
    q.amount_2 = a2[7:0];
    q.amount_3 = a3[7:0];
    return q;
  endfunction

  function automatic int gap();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // Offer one item and hold it until accepted; valid stays high afterwards.
  task automatic send(bra_pkg::req_t q, logic [3:0] typed);
    rsp_q.push_back(admit(q));
    typed_q.push_back(typed);
    req <= q;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
  endtask

  // Random item, biased toward well-formed requests and releases.
  function automatic bra_pkg::req_t rand_item();
    int k;
    int c;
    int a [4];
    k = $urandom_range(0, 99);
    c = ($urandom_range(0, 15) == 0) ? $urandom_range(NCust, 7) : $urandom_range(0, NCust - 1);
    for (int r = 0; r < 4; r++) begin
      if ($urandom_range(0, 9) == 0) a[r] = $urandom_range(0, 255);
      else if (k < 60 && r < NRes && c < NCust) a[r] = $urandom_range(0, need(c, r));
      else a[r] = $urandom_range(0, 12);
    end
    if (k < 8) begin
      for (int r = 0; r < 4; r++) if ($urandom_range(0, 3) != 0) a[r] = $urandom_range(5, 40);
      return mk(bra_pkg::CMD_LOAD_FREE, $urandom_range(0, 7), a[0], a[1], a[2], a[3]);
    end
    if (k < 16) return mk(bra_pkg::CMD_LOAD_MAX, c, a[0], a[1], a[2], a[3]);
    if (k < 70) return mk(bra_pkg::CMD_REQUEST, c, a[0], a[1], a[2], a[3]);
    return mk(bra_pkg::CMD_RELEASE, c, a[0], a[1], a[2], a[3]);
  endfunction

  initial begin
    bra_pkg::req_t dir [NDir];
    logic [3:0] dst [NDir];
    int g;
    for (int c = 0; c < NCust; c++)
      for (int r = 0; r < NRes; r++) begin
        claim_t[c][r] = 0;
        held_t[c][r] = 0;
      end
    for (int r = 0; r < NRes; r++) free_v[r] = 0;
    dir[0]  = mk(bra_pkg::CMD_REQUEST, 0, 0, 0, 0, 0);     dst[0]  = bra_pkg::ST_GRANTED;
    dir[1]  = mk(bra_pkg::CMD_REQUEST, 0, 1, 0, 0, 0);     dst[1]  = bra_pkg::ST_CLAIM;
    dir[2]  = mk(bra_pkg::CMD_LOAD_MAX, 5, 1, 1, 1, 1);    dst[2]  = bra_pkg::ST_BADCUST;
    dir[3]  = mk(bra_pkg::CMD_REQUEST, 7, 0, 0, 0, 0);     dst[3]  = bra_pkg::ST_BADCUST;
    dir[4]  = mk(bra_pkg::CMD_RELEASE, 6, 9, 9, 9, 9);     dst[4]  = bra_pkg::ST_BADCUST;
    dir[5]  = mk(bra_pkg::CMD_LOAD_FREE, 7, 255, 0, 170, 85); dst[5] = bra_pkg::ST_DONE;
    dir[6]  = mk(bra_pkg::CMD_LOAD_FREE, 3, 10, 5, 7, 2);  dst[6]  = bra_pkg::ST_DONE;
    dir[7]  = mk(bra_pkg::CMD_LOAD_MAX, 0, 7, 5, 3, 2);    dst[7]  = bra_pkg::ST_DONE;
    dir[8]  = mk(bra_pkg::CMD_LOAD_MAX, 1, 3, 2, 2, 2);    dst[8]  = bra_pkg::ST_DONE;
    dir[9]  = mk(bra_pkg::CMD_LOAD_MAX, 2, 9, 0, 2, 2);    dst[9]  = bra_pkg::ST_DONE;
    dir[10] = mk(bra_pkg::CMD_LOAD_MAX, 3, 2, 2, 2, 2);    dst[10] = bra_pkg::ST_DONE;
    dir[11] = mk(bra_pkg::CMD_LOAD_MAX, 4, 255, 255, 255, 255); dst[11] = bra_pkg::ST_DONE;
    dir[12] = mk(bra_pkg::CMD_REQUEST, 1, 4, 0, 0, 0);     dst[12] = bra_pkg::ST_CLAIM;
    dir[13] = mk(bra_pkg::CMD_REQUEST, 4, 20, 0, 0, 0);    dst[13] = bra_pkg::ST_FREE;
    dir[14] = mk(bra_pkg::CMD_REQUEST, 1, 2, 0, 0, 0);     dst[14] = STX;
    dir[15] = mk(bra_pkg::CMD_REQUEST, 4, 8, 5, 7, 2);     dst[15] = STX;
    dir[16] = mk(bra_pkg::CMD_RELEASE, 1, 200, 0, 0, 0);   dst[16] = bra_pkg::ST_DONE;
    dir[17] = mk(bra_pkg::CMD_LOAD_MAX, 1, 0, 0, 0, 0);    dst[17] = bra_pkg::ST_DONE;
    dir[18] = mk(bra_pkg::CMD_LOAD_FREE, 0, 250, 255, 254, 253); dst[18] = bra_pkg::ST_DONE;
    dir[19] = mk(bra_pkg::CMD_RELEASE, 4, 255, 255, 255, 255); dst[19] = bra_pkg::ST_DONE;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < NDir; i++) send(dir[i], dst[i]);
    for (int i = 0; i < NRand; i++) begin
      if (i == 300) hold_off = 200;
      if (i == 700) begin
        // drain: drop valid and wait for every expected response
        req_valid <= 1'b0;
        wait (rsp_q.size() == 0);
        @(posedge clk);
      end
      g = gap();
      if (g > 0) begin
        req_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
      send(rand_item(), STX);
    end
    req_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int g;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        rsp_ready <= 1'b0;
        hold_off--;
      end else begin
        g = gap();
        if (g > 0) begin
          rsp_ready <= 1'b0;
          repeat (g - 1) @(posedge clk);
          @(posedge clk);
        end
        rsp_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    bra_pkg::rsp_t e;
    logic [3:0] t;
    if (rst_n && rsp_valid && rsp_ready) begin
      if (rsp_q.size() == 0) begin
        $display("%0t: unexpected response %h", $time, rsp);
        errors++;
      end else begin
        e = rsp_q.pop_front();
        t = typed_q.pop_front();
        if (t != STX && t[2:0] != e.status) begin
          $display("%0t: table status expected %0d predicted %0d", $time, t, e.status);
          errors++;
        end
        if (rsp.status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, rsp.status);
          errors++;
        end
        if (rsp.free_0 !== e.free_0 || rsp.free_1 !== e.free_1 ||
            rsp.free_2 !== e.free_2 || rsp.free_3 !== e.free_3) begin
          $display("%0t: free expected %h actual %h", $time,
                   {e.free_0, e.free_1, e.free_2, e.free_3},
                   {rsp.free_0, rsp.free_1, rsp.free_2, rsp.free_3});
          errors++;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    wait (rsp_q.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && rsp_q.size() == 0) begin
      $display("bankers_resource_admission_unit regression: pass");
    end else begin
      $display("bankers_resource_admission_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("bankers_resource_admission_unit regression: fail");
    $finish;
  end
endmodule
`default_nettype wire
